[sv/strmq_pkg.sv]
// Shared widths, defaults and request codes for the sparse-table range-max engine.
`timescale 1ns / 1ps
package strmq_pkg;

  localparam int DATA_W = 32;
  localparam int END_W  = 11;

  localparam int DEF_MAX_ELEMENTS = 1024;
  localparam int DEF_LEVEL_COUNT  = 11;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

endpackage

[sv/strmq_req_if.sv]
// Request channel: load or query items with valid/ready handshake.
`timescale 1ns / 1ps
interface strmq_req_if
  import strmq_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic signed [DATA_W-1:0] value;
  logic                     last;
  logic [END_W-1:0]         left_end;
  logic [END_W-1:0]         right_end;

  modport source (output valid, req_type, value, last, left_end, right_end, input ready);
  modport sink   (input valid, req_type, value, last, left_end, right_end, output ready);
endinterface

[sv/strmq_res_if.sv]
// Result channel: range maximum and error flag with valid/ready handshake.
`timescale 1ns / 1ps
interface strmq_res_if
  import strmq_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] range_max;
  logic                     query_error;

  modport source (output valid, range_max, query_error, input ready);
  modport sink   (input valid, range_max, query_error, output ready);
endinterface

[sv/sparse_table_range_max.sv]
// Sparse-table range-maximum engine: one table memory, one shared compare unit.
`timescale 1ns / 1ps
// Range-maximum engine on a sparse table held in one single-port-write, single-read memory
// of LEVEL_COUNT rows by 2^IW words (MAX_ELEMENTS rounded up to a power of two). A load
// item writes the next level-0 entry while the array is not full; a load after a finished
// build starts a new array. The load marked last starts the build, during which no item is
// accepted: each entry of level k takes a check, two reads through the single read port
// and one write, each level ends with one extra check, and one closing check marks the
// table ready.
// A query finds the window level one bit a step, then reads the two windows one after
// the other and compares them. A query with a bad end or no built table goes straight to
// the compare state and returns an error. The result sits in an output register, so the
// next item is taken while it waits.
module sparse_table_range_max
  import strmq_pkg::*;
#(
  parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
  parameter int LEVEL_COUNT  = DEF_LEVEL_COUNT
) (
  input  logic        clk,
  input  logic        rst,
  strmq_req_if.sink   req,
  strmq_res_if.source res
);

  localparam int IW    = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW    = $clog2(MAX_ELEMENTS + 1);
  localparam int HW    = CW + 1;
  localparam int LW    = $clog2(LEVEL_COUNT);
  localparam int LVW   = $clog2(LEVEL_COUNT + 1);
  localparam int AW    = LW + IW;
  localparam int DEPTH = LEVEL_COUNT * (2 ** IW);
  localparam int EW    = (CW > END_W) ? CW : END_W;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_B_CHK  = 9'b000000010,
    S_B_RD_A = 9'b000000100,
    S_B_RD_B = 9'b000001000,
    S_B_WR   = 9'b000010000,
    S_Q_LOG  = 9'b000100000,
    S_Q_RD_A = 9'b001000000,
    S_Q_RD_B = 9'b010000000,
    S_Q_CMP  = 9'b100000000
  } state_t;

  function automatic logic signed [DATA_W-1:0] smax(input logic signed [DATA_W-1:0] a,
                                                    input logic signed [DATA_W-1:0] b);
    return (a >= b) ? a : b;
  endfunction

  state_t state;

  logic [CW-1:0]  count;
  logic           table_ready;
  logic [LVW-1:0] lvl;
  logic [HW-1:0]  span;     // build: 2^(lvl-1); query: 2^lvl
  logic [IW-1:0]  idx;
  logic [IW-1:0]  q_lo;
  logic [IW-1:0]  q_hi;
  logic [CW-1:0]  q_len;
  logic           q_err;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rd_data;
  logic signed [DATA_W-1:0] hold;
  logic signed [DATA_W-1:0] cmp_max;

  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic signed [DATA_W-1:0] wr_data;

  logic acc;
  logic is_load;
  logic load_wr;
  logic out_free;

  logic [EW-1:0] l_ext, r_ext, cnt_ext, lo_ext, hi_ext, len_ext;
  logic          q_bad;

  logic [HW-1:0] idx_far;   // idx + half
  logic [HW-1:0] q_far;     // hi + 1 - span
  logic [LW-1:0] lvl_a;
  logic [LW-1:0] lvl_prev;

  assign req.ready = (state == S_IDLE);
  assign acc       = req.valid && req.ready;
  assign is_load   = (req.req_type == REQ_LOAD);
  assign load_wr   = acc && is_load && (table_ready || count < CW'(MAX_ELEMENTS));
  assign out_free  = !res.valid || res.ready;

  assign l_ext   = EW'(req.left_end);
  assign r_ext   = EW'(req.right_end);
  assign cnt_ext = EW'(count);
  assign q_bad   = !table_ready || l_ext == '0 || r_ext == '0 ||
                   l_ext > cnt_ext || r_ext > cnt_ext;
  assign lo_ext  = ((l_ext <= r_ext) ? l_ext : r_ext) - EW'(1);
  assign hi_ext  = ((l_ext <= r_ext) ? r_ext : l_ext) - EW'(1);
  assign len_ext = hi_ext - lo_ext + EW'(1);

  assign idx_far  = HW'(idx) + span;
  assign q_far    = HW'(q_hi) + HW'(1) - span;
  assign lvl_a    = lvl[LW-1:0];
  assign lvl_prev = LW'(lvl - LVW'(1));

  // shared compare unit
  assign cmp_max = smax(hold, rd_data);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (state)
      S_B_RD_A: begin
        rd_en   = 1'b1;
        rd_addr = {lvl_prev, idx};
      end
      S_B_RD_B: begin
        rd_en   = 1'b1;
        rd_addr = {lvl_prev, idx_far[IW-1:0]};
      end
      S_Q_RD_A: begin
        rd_en   = 1'b1;
        rd_addr = {lvl_a, q_lo};
      end
      S_Q_RD_B: begin
        rd_en   = 1'b1;
        rd_addr = {lvl_a, q_far[IW-1:0]};
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = '0;
      end
    endcase
  end

  always_comb begin
    if (state == S_B_WR) begin
      wr_en   = 1'b1;
      wr_addr = {lvl_a, idx};
      wr_data = cmp_max;
    end else begin
      wr_en   = load_wr;
      wr_addr = {LW'(0), (table_ready ? IW'(0) : count[IW-1:0])};
      wr_data = req.value;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      table_ready <= 1'b0;
      res.valid   <= 1'b0;
    end else begin
      // the compare state sets valid itself when the output register frees up
      if (res.valid && res.ready && state != S_Q_CMP) res.valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (acc) begin
            if (is_load) begin
              if (table_ready) begin
                table_ready <= 1'b0;
                count       <= CW'(1);
              end else if (count < CW'(MAX_ELEMENTS)) begin
                count <= count + CW'(1);
              end
              if (req.last) begin
                lvl   <= LVW'(1);
                span  <= HW'(1);
                idx   <= '0;
                state <= S_B_CHK;
              end
            end else begin
              q_err <= q_bad;
              q_lo  <= lo_ext[IW-1:0];
              q_hi  <= hi_ext[IW-1:0];
              q_len <= len_ext[CW-1:0];
              lvl   <= '0;
              span  <= HW'(1);
              state <= q_bad ? S_Q_CMP : S_Q_LOG;
            end
          end
        end

        S_B_CHK: begin
          if (lvl < LVW'(LEVEL_COUNT) && span < HW'(count)) begin
            if (idx_far < HW'(count)) begin
              state <= S_B_RD_A;
            end else begin
              lvl  <= lvl + LVW'(1);
              span <= span << 1;
              idx  <= '0;
            end
          end else begin
            table_ready <= 1'b1;
            state       <= S_IDLE;
          end
        end

        S_B_RD_A: state <= S_B_RD_B;

        S_B_RD_B: begin
          hold  <= rd_data;
          state <= S_B_WR;
        end

        S_B_WR: begin
          idx   <= idx + IW'(1);
          state <= S_B_CHK;
        end

        // window level: largest power of two not above the length, clamped to the top level
        S_Q_LOG: begin
          if (lvl < LVW'(LEVEL_COUNT - 1) && (span << 1) <= HW'(q_len)) begin
            lvl  <= lvl + LVW'(1);
            span <= span << 1;
          end else begin
            state <= S_Q_RD_A;
          end
        end

        S_Q_RD_A: state <= S_Q_RD_B;

        S_Q_RD_B: begin
          hold  <= rd_data;
          state <= S_Q_CMP;
        end

        S_Q_CMP: begin
          if (out_free) begin
            res.valid       <= 1'b1;
            res.range_max   <= q_err ? '0 : cmp_max;
            res.query_error <= q_err;
            state           <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
